/* hw/rtl/kfdx_pkg.sv */
// Shared types and constants for the KISS frame decoder with XOR check.
package kfdx_pkg;

   // Frame storage bound and derived widths
   localparam int MaxFrame     = 512;
   localparam int CountWidth   = $clog2(MaxFrame + 1);
   localparam int ByteWidth    = 8;
   localparam int LengthWidth  = 10;
   localparam int CounterWidth = 16;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 10;

   // KISS special codes
   localparam logic [ByteWidth-1:0] KissFend  = 8'o300;
   localparam logic [ByteWidth-1:0] KissFesc  = 8'o333;
   localparam logic [ByteWidth-1:0] KissTfend = 8'o334;
   localparam logic [ByteWidth-1:0] KissTfesc = 8'o335;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrUseChecksum = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxLength   = 1'd1;

   // Reset values of the configuration registers
   localparam logic [CsrDataWidth-1:0] MaxLengthReset = 10'd400;

   // Frame end status codes
   localparam logic [1:0] StatusGood      = 2'd0;
   localparam logic [1:0] StatusDangling  = 2'd1;
   localparam logic [1:0] StatusTooLong   = 2'd2;
   localparam logic [1:0] StatusBadXor    = 2'd3;

   // Configuration as seen by the decoder
   typedef struct packed {
      logic                  use_checksum;
      logic [CountWidth-1:0] limit;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [ByteWidth-1:0]    data_byte;
      logic                    data_valid;
      logic                    frame_end;
      logic [1:0]              frame_status;
      logic [LengthWidth-1:0]  frame_length;
      logic [CounterWidth-1:0] protocol_errors;
      logic [CounterWidth-1:0] checksum_errors;
      logic [CounterWidth-1:0] good_frames;
   } rsp_item_type;

endpackage

/* hw/rtl/kfdx_if.sv */
// Channel interfaces: raw byte input, decoded result output, register writes.
interface kfdx_req_if;
   import kfdx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kfdx_rsp_if;
   import kfdx_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ByteWidth-1:0]    data_byte;
   logic                    data_valid;
   logic                    frame_end;
   logic [1:0]              frame_status;
   logic [LengthWidth-1:0]  frame_length;
   logic [CounterWidth-1:0] protocol_errors;
   logic [CounterWidth-1:0] checksum_errors;
   logic [CounterWidth-1:0] good_frames;
   modport source (output valid, output data_byte, output data_valid, output frame_end,
                   output frame_status, output frame_length, output protocol_errors,
                   output checksum_errors, output good_frames, input ready);
   modport sink   (input valid, input data_byte, input data_valid, input frame_end,
                   input frame_status, input frame_length, input protocol_errors,
                   input checksum_errors, input good_frames, output ready);
endinterface

interface kfdx_csr_if;
   import kfdx_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/kfdx_csr.sv */
// Configuration registers: checksum enable and clamped frame length limit.
module kfdx_csr (
   input  logic             clock,
   input  logic             reset,
   kfdx_csr_if.sink         csr_if,
   output kfdx_pkg::cfg_type cfg
);
   import kfdx_pkg::*;

   logic                  use_checksum_ff;
   logic                  use_checksum_in;
   logic [CountWidth-1:0] limit_ff;
   logic [CountWidth-1:0] limit_in;
   logic                  wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;

   // Limit is stored already clamped to 1 .. MaxFrame
   always_comb begin
      use_checksum_in = use_checksum_ff;
      limit_in        = limit_ff;
      if (wr_en) begin
         case (csr_if.index)
            CsrUseChecksum: use_checksum_in = csr_if.data[0];
            CsrMaxLength: begin
               if (csr_if.data == '0) begin
                  limit_in = CountWidth'(1);
               end else if (CountWidth'(csr_if.data) > CountWidth'(MaxFrame)
                            || csr_if.data > CsrDataWidth'(MaxFrame)) begin
                  limit_in = CountWidth'(MaxFrame);
               end else begin
                  limit_in = CountWidth'(csr_if.data);
               end
            end
            default: limit_in = limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_checksum_ff <= 1'b1;
         limit_ff        <= CountWidth'(MaxLengthReset);
      end else begin
         use_checksum_ff <= use_checksum_in;
         limit_ff        <= limit_in;
      end
   end

   assign cfg.use_checksum = use_checksum_ff;
   assign cfg.limit        = limit_ff;

endmodule

/* hw/rtl/kfdx_decoder.sv */
// Deframer: input register, escape/frame state update and result register.
module kfdx_decoder (
   input  logic              clock,
   input  logic              reset,
   input  kfdx_pkg::cfg_type cfg,
   kfdx_req_if.sink          req_if,
   kfdx_rsp_if.source        rsp_if
);
   import kfdx_pkg::*;

   // Input register
   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;

   // Frame state
   logic                    esc_ff, esc_in;
   logic [ByteWidth-1:0]    xor_ff, xor_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [ByteWidth-1:0]    held_ff, held_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    ovf_ff, ovf_in;
   logic [CounterWidth-1:0] proto_ff, proto_in;
   logic [CounterWidth-1:0] xerr_ff, xerr_in;
   logic [CounterWidth-1:0] good_ff, good_in;

   // Result register
   logic         out_valid_ff;
   rsp_item_type out_ff;
   logic         emit;
   rsp_item_type item;

   logic                  advance;
   logic                  fire;
   logic                  is_fend;
   logic                  is_fesc;
   logic [ByteWidth-1:0]  decoded;
   logic [1:0]            status;
   logic [CountWidth-1:0] len;

   // Handshake: the stage moves when the result register is free or being taken
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign fire         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   assign is_fend = (in_byte_ff == KissFend);
   assign is_fesc = (in_byte_ff == KissFesc);

   // Next state and result for the byte in the input register
   always_comb begin
      esc_in        = esc_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      ovf_in        = ovf_ff;
      proto_in      = proto_ff;
      xerr_in       = xerr_ff;
      good_in       = good_ff;
      emit          = 1'b0;
      decoded       = in_byte_ff;
      status        = StatusGood;
      len           = count_ff - CountWidth'(cfg.use_checksum);
      item          = '0;

      if (is_fend) begin
         // Frame end: decide status, then clear the frame
         if (esc_ff) begin
            status   = StatusDangling;
         end else if (ovf_ff) begin
            status   = StatusTooLong;
         end else if (cfg.use_checksum && xor_ff != '0) begin
            status   = StatusBadXor;
         end
         if (count_ff != '0) begin
            if (status == StatusDangling) begin
               proto_in = proto_ff + CounterWidth'(1);
            end
            if (status == StatusBadXor) begin
               xerr_in = xerr_ff + CounterWidth'(1);
            end
            if (status == StatusGood && len != '0) begin
               good_in = good_ff + CounterWidth'(1);
            end
            emit = !(status == StatusGood && len == '0);
         end
         item.data_valid   = !cfg.use_checksum && held_valid_ff;
         item.data_byte    = item.data_valid ? held_ff : '0;
         item.frame_end    = 1'b1;
         item.frame_status = status;
         item.frame_length = LengthWidth'(len);
         esc_in        = 1'b0;
         xor_in        = '0;
         count_in      = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
         ovf_in        = 1'b0;
      end else if (is_fesc) begin
         esc_in = 1'b1;
      end else begin
         // Undo escapes; an unknown code after FESC is kept and counted
         if (esc_ff) begin
            esc_in = 1'b0;
            if (in_byte_ff == KissTfend) begin
               decoded = KissFend;
            end else if (in_byte_ff == KissTfesc) begin
               decoded = KissFesc;
            end else begin
               proto_in = proto_ff + CounterWidth'(1);
            end
         end
         if (count_ff >= cfg.limit) begin
            ovf_in = 1'b1;
         end else begin
            emit           = held_valid_ff;
            item.data_byte  = held_ff;
            item.data_valid = 1'b1;
            held_in        = decoded;
            held_valid_in  = 1'b1;
            count_in       = count_ff + CountWidth'(1);
            xor_in         = xor_ff ^ decoded;
         end
      end

      item.protocol_errors = proto_in;
      item.checksum_errors = xerr_in;
      item.good_frames     = good_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         esc_ff        <= 1'b0;
         xor_ff        <= '0;
         count_ff      <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         proto_ff      <= '0;
         xerr_ff       <= '0;
         good_ff       <= '0;
      end else begin
         // Input register
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_if.rx_byte;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         // State and result register
         if (fire) begin
            out_valid_ff  <= emit;
            out_ff        <= item;
            esc_ff        <= esc_in;
            xor_ff        <= xor_in;
            count_ff      <= count_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            ovf_ff        <= ovf_in;
            proto_ff      <= proto_in;
            xerr_ff       <= xerr_in;
            good_ff       <= good_in;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.data_byte       = out_ff.data_byte;
   assign rsp_if.data_valid      = out_ff.data_valid;
   assign rsp_if.frame_end       = out_ff.frame_end;
   assign rsp_if.frame_status    = out_ff.frame_status;
   assign rsp_if.frame_length    = out_ff.frame_length;
   assign rsp_if.protocol_errors = out_ff.protocol_errors;
   assign rsp_if.checksum_errors = out_ff.checksum_errors;
   assign rsp_if.good_frames     = out_ff.good_frames;

   // The held byte is present exactly when the frame has stored bytes
   assert property (@(posedge clock) disable iff (reset)
      held_valid_ff == (count_ff != '0))
      else $error("held byte flag out of step with byte count");

   // Overflow can only be flagged once bytes are stored
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff != '0)
      else $error("overflow flagged on an empty frame");

   // A frame end always leaves the frame empty
   assert property (@(posedge clock) disable iff (reset)
      fire && is_fend |=> count_ff == '0 && !esc_ff)
      else $error("frame state not cleared at frame end");

   // A good frame is never reported with zero length
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.frame_end && out_ff.frame_status == StatusGood
      |-> out_ff.frame_length != '0)
      else $error("good frame with zero length");

endmodule

/* hw/rtl/kiss_frame_decoder_xor_check_core.sv */
// Top level of the KISS frame decoder with XOR checksum.
//
//   channel   direction  payload                                   handshake
//   req_if    in         rx_byte                                   valid/ready
//   rsp_if    out        data/frame status/length/running counts   valid/ready
//   csr_if    in         index, data (use_checksum, max_length)    valid/ready
//
// One byte per cycle while rsp_if takes results: each byte passes an input
// register, then one short update of the frame state writes the result register.
// Reset is synchronous and clears all frame state and counters.
// When the result register holds an untaken item, a byte in the input register
// waits there and req_if.ready stays low until rsp_if.ready returns.
module kiss_frame_decoder_xor_check_core (
   input  logic        clock,
   input  logic        reset,
   kfdx_req_if.sink    req_if,
   kfdx_rsp_if.source  rsp_if,
   kfdx_csr_if.sink    csr_if
);
   import kfdx_pkg::*;

   cfg_type cfg;

   kfdx_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   kfdx_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
